// File: design/assert_macros.svh
// Assertion helpers included by natural_log_series.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// File: design/lns_pkg.sv
// ----------------------------------------------------------------------------
// lns_pkg
// Constants, series coefficients and stage payload types of the log pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lns_pkg;

    localparam int TERMS         = 20;
    localparam int HORNER_STAGES = TERMS - 1;
    localparam int DIV_BITS      = 31;
    localparam int FRAC_Z        = 30;

    localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
    localparam logic [31:0] LOG_INVALID = 32'h8000_0000;

    typedef logic [31:0] coef_arr_t [0:31];

    // round(2^30 / (2k+1)), k = 0..31
    localparam coef_arr_t COEF = '{
        32'd1073741824, 32'd357913941, 32'd214748365, 32'd153391689,
        32'd119304647,  32'd97612893,  32'd82595525,  32'd71582788,
        32'd63161284,   32'd56512728,  32'd51130563,  32'd46684427,
        32'd42949673,   32'd39768216,  32'd37025580,  32'd34636833,
        32'd32537631,   32'd30678338,  32'd29020049,  32'd27531842,
        32'd26188825,   32'd24970740,  32'd23860929,  32'd22845571,
        32'd21913098,   32'd21053761,  32'd20259280,  32'd19522579,
        32'd18837576,   32'd18199014,  32'd17602325,  32'd17043521
    };

    typedef struct packed {
        logic [32:0] rem;
        logic [30:0] low;
        logic [32:0] den;
        logic [30:0] quo;
        logic        neg;
        logic        inv;
    } div_data_t;

    typedef struct packed {
        logic [31:0] acc;
        logic [29:0] w;
        logic [29:0] z;
        logic        neg;
        logic        inv;
    } hor_data_t;

endpackage

// File: design/lns_div.sv
// ----------------------------------------------------------------------------
// lns_div
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lns_div
    import lns_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  div_data_t in_data,
    output logic      out_valid,
    output div_data_t out_data
);

    logic      valid_reg [DIV_BITS];
    div_data_t data_reg  [DIV_BITS];
    div_data_t data_next [DIV_BITS];

    for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
        div_data_t   prev;
        logic        prev_valid;
        logic [33:0] rem_sh;
        logic [33:0] diff;

        if (i == 0) begin : g_first
            assign prev       = in_data;
            assign prev_valid = in_valid;
        end else begin : g_rest
            assign prev       = data_reg[i-1];
            assign prev_valid = valid_reg[i-1];
        end

        always_comb
        begin
            rem_sh       = {prev.rem, prev.low[30]};
            diff         = rem_sh - {1'b0, prev.den};
            data_next[i] = prev;
            data_next[i].low = {prev.low[29:0], 1'b0};
            // keep the difference when the divisor fits
            if (rem_sh >= {1'b0, prev.den})
            begin
                data_next[i].rem = diff[32:0];
                data_next[i].quo = {prev.quo[29:0], 1'b1};
            end
            else
            begin
                data_next[i].rem = rem_sh[32:0];
                data_next[i].quo = {prev.quo[29:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                data_reg[i] <= data_next[i];
        end
    end

    assign out_valid = valid_reg[DIV_BITS-1];
    assign out_data  = data_reg[DIV_BITS-1];

endmodule

// File: design/natural_log_series.sv
// ----------------------------------------------------------------------------
// natural_log_series
// Natural logarithm by the truncated atanh series, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: x_value (unsigned Q16.16) on in_valid / in_stall.
//   Output beat: log_value (signed Q8.24) and invalid on out_valid / out_stall.
//   z = (x-1)/(x+1) comes from a 31-stage restoring divider, one quotient
//   bit per stage, fed by one input register. One stage squares z, then one
//   stage per Horner step (TERMS-1 of them) does a multiply-add in z^2, one
//   stage multiplies by z and one stage applies the sign.
//   34 + TERMS register stages (54 with 20 terms). Throughput: one beat
//   per cycle when not stalled; each Horner stage holds one multiplier.
//   A zero argument gives invalid = 1 and the most negative log_value.
//   Reset clears every stage valid bit; the pipeline comes up empty.
//   While a result waits under out_stall the whole pipeline holds and
//   in_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module natural_log_series
    import lns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] x_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] log_value,
    output logic        invalid
);

    // advance every stage together unless the output beat is held
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // ---------------- input stage: numerator, denominator, dividend ----------
    logic        s0_valid_reg;
    div_data_t   s0_reg;
    div_data_t   s0_next;
    logic        x_neg;
    logic [31:0] num_mag;
    logic [32:0] den;
    logic [63:0] dividend;

    always_comb
    begin
        x_neg    = (x_value < ONE_Q16);
        num_mag  = x_neg ? (ONE_Q16 - x_value) : (x_value - ONE_Q16);
        den      = {1'b0, x_value} + {1'b0, ONE_Q16};
        // rounded division: add half the divisor up front
        dividend = {2'b00, num_mag, 30'b0} + {31'b0, 1'b0, den[32:1]};
        s0_next.rem = dividend[63:31];
        s0_next.low = dividend[30:0];
        s0_next.den = den;
        s0_next.quo = '0;
        s0_next.neg = x_neg;
        s0_next.inv = (x_value == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s0_reg <= s0_next;
    end

    // ---------------- divider ----------------
    logic      dv_valid;
    div_data_t dv_data;

    lns_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_data   (s0_reg),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    // ---------------- square stage: w = round(z*z / 2^30) ----------------
    logic        sq_valid_reg;
    hor_data_t   sq_reg;
    hor_data_t   sq_next;
    logic [59:0] sq_prod;

    always_comb
    begin
        sq_prod      = {30'b0, dv_data.quo[29:0]} * {30'b0, dv_data.quo[29:0]}
                       + 60'd536870912;
        sq_next.acc  = COEF[TERMS-1];
        sq_next.w    = sq_prod[59:30];
        sq_next.z    = dv_data.quo[29:0];
        sq_next.neg  = dv_data.neg;
        sq_next.inv  = dv_data.inv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else if (en)
            sq_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sq_reg <= sq_next;
    end

    // ---------------- Horner stages: acc = c_k + round(acc*w / 2^30) --------
    logic      hn_valid_reg [HORNER_STAGES];
    hor_data_t hn_reg       [HORNER_STAGES];
    hor_data_t hn_next      [HORNER_STAGES];

    for (genvar j = 0; j < HORNER_STAGES; j++) begin : g_horner
        hor_data_t   prev;
        logic        prev_valid;
        logic [61:0] prod;

        if (j == 0) begin : g_first
            assign prev       = sq_reg;
            assign prev_valid = sq_valid_reg;
        end else begin : g_rest
            assign prev       = hn_reg[j-1];
            assign prev_valid = hn_valid_reg[j-1];
        end

        always_comb
        begin
            prod           = {30'b0, prev.acc} * {32'b0, prev.w} + 62'd536870912;
            hn_next[j]     = prev;
            hn_next[j].acc = COEF[TERMS-2-j] + prod[61:30];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                hn_valid_reg[j] <= 1'b0;
            else if (en)
                hn_valid_reg[j] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                hn_reg[j] <= hn_next[j];
        end
    end

    // ---------------- final multiply: round(acc*|z| / 2^35) ----------------
    logic        fm_valid_reg;
    logic [26:0] fm_mag_reg;
    logic        fm_neg_reg;
    logic        fm_inv_reg;
    logic [61:0] fm_prod;
    hor_data_t   hn_last;

    assign hn_last = hn_reg[HORNER_STAGES-1];
    assign fm_prod = {30'b0, hn_last.acc} * {32'b0, hn_last.z} + 62'd17179869184;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fm_valid_reg <= 1'b0;
        else if (en)
            fm_valid_reg <= hn_valid_reg[HORNER_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fm_mag_reg <= fm_prod[61:35];
            fm_neg_reg <= hn_last.neg;
            fm_inv_reg <= hn_last.inv;
        end
    end

    // ---------------- output stage: sign and invalid override ----------------
    logic        out_valid_reg;
    logic [31:0] log_reg;
    logic [31:0] log_next;
    logic        inv_reg;

    always_comb
    begin
        if (fm_inv_reg)
            log_next = LOG_INVALID;
        else if (fm_neg_reg)
            log_next = 32'd0 - {5'b0, fm_mag_reg};
        else
            log_next = {5'b0, fm_mag_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= fm_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            log_reg <= log_next;
            inv_reg <= fm_inv_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign log_value = log_reg;
    assign invalid   = inv_reg;

    // ---------------- assertions ----------------
    `ASSERT_IMPLIES(a_inv_value, clk, rst_n, out_valid && invalid, log_value == LOG_INVALID)
    `ASSERT_NEXT(a_hold_horner, clk, rst_n, out_valid && out_stall, $stable(hn_last))
    `ASSERT_NEXT(a_hold_final, clk, rst_n, out_valid && out_stall, $stable(fm_mag_reg))

endmodule

// File: tb/natural_log_series_tb.sv
// ----------------------------------------------------------------------------
// natural_log_series_tb
// Drives unsigned Q16.16 arguments into the log pipeline and compares every
// output beat with a bit-exact atanh-series prediction, under random gaps
// and random output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module natural_log_series_tb;
    import lns_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2 * (35 + TERMS) + 20;
    localparam int RANDOM_ITEMS   = 1700;

    typedef struct {
        logic [31:0] log_value;
        logic        invalid;
    } log_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] x_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] log_value;
    logic        invalid;

    logic [31:0] pending_args[$];
    log_result_t expected_logs[$];
    int          error_count;
    int          beats_in;
    int          beats_out;
    int          invalid_seen;
    int          idle_cycles;
    bit          stim_done;
    int          send_gap;
    int          stall_len;

    natural_log_series uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_value   (x_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .log_value (log_value),
        .invalid   (invalid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Round-half-up right shift on a 64-bit value.
    function automatic logic [63:0] rshift_round(logic [63:0] v, int s);
        return (v + (64'd1 << (s - 1))) >> s;
    endfunction

    // Predict ln(x) in Q8.24 by Horner evaluation of the atanh series.
    function automatic log_result_t predict_log(logic [31:0] x);
        log_result_t r;
        logic [63:0] num_mag;
        logic [63:0] den;
        logic [63:0] zmag;
        logic [63:0] w;
        logic [63:0] acc;
        logic [63:0] mag;
        logic [63:0] d;
        logic        neg;
        if (x == 32'd0)
        begin
            r.log_value = LOG_INVALID;
            r.invalid   = 1'b1;
            return r;
        end
        neg     = (x < ONE_Q16);
        num_mag = neg ? 64'(ONE_Q16 - x) : 64'(x) - 64'(ONE_Q16);
        den     = 64'(x) + 64'(ONE_Q16);
        zmag    = ((num_mag << FRAC_Z) + den / 2) / den;
        w       = rshift_round(zmag * zmag, FRAC_Z);
        d       = 64'(2 * (TERMS - 1) + 1);
        acc     = ((64'd1 << FRAC_Z) + d / 2) / d;
        for (int k = TERMS - 2; k >= 0; k--)
        begin
            d   = 64'(2 * k + 1);
            acc = ((64'd1 << FRAC_Z) + d / 2) / d + rshift_round(acc * w, FRAC_Z);
        end
        mag         = rshift_round(acc * zmag, 35) & 64'hFFFF_FFFF;
        r.log_value = neg ? 32'(0) - mag[31:0] : mag[31:0];
        r.invalid   = 1'b0;
        return r;
    endfunction

    // Most often no gap, else mostly a short one, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] random_arg();
        int p;
        p = $urandom_range(0, 9);
        case (p)
            0: return $urandom_range(0, 3);
            1: return ONE_Q16 + $urandom_range(0, 8) - 4;
            2: return $urandom_range(0, 32'h0001_FFFF);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
            4: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // Directed corner arguments, then the random stream.
    initial
    begin
        pending_args.push_back(32'h0000_0000);
        pending_args.push_back(32'h0000_0001);
        pending_args.push_back(32'h0000_0002);
        pending_args.push_back(ONE_Q16);
        pending_args.push_back(ONE_Q16 - 1);
        pending_args.push_back(ONE_Q16 + 1);
        pending_args.push_back(32'h0000_8000);
        pending_args.push_back(32'h0002_0000);
        pending_args.push_back(32'h0002_B7E1);
        pending_args.push_back(32'h7FFF_FFFF);
        pending_args.push_back(32'h8000_0000);
        pending_args.push_back(32'hFFFF_FFFF);
        pending_args.push_back(32'hFFFF_FFFE);
        pending_args.push_back(32'hAAAA_AAAA);
        pending_args.push_back(32'h5555_5555);
        pending_args.push_back(32'h0000_0000);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_args.push_back(random_arg());
    end

    // Reset once; release it away from the clock edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        #1 rst_n = 1'b1;
    end

    // Driver: present the next argument after a random gap, hold it while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            x_value   <= '0;
            send_gap  <= 0;
            beats_in  <= 0;
            stim_done <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_logs.push_back(predict_log(x_value));
                beats_in <= beats_in + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_args.size() > 0)
                begin
                    in_valid <= 1'b1;
                    x_value  <= pending_args.pop_front();
                    send_gap <= pick_gap();
                end
                else
                begin
                    in_valid  <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // Monitor: check every accepted output beat, then pick the next stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        log_result_t want;
        int          errs;
        errs = 0;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            stall_len    <= 0;
            beats_out    <= 0;
            error_count  <= 0;
            invalid_seen <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_out <= beats_out + 1;
                if (expected_logs.size() == 0)
                begin
                    $error("unexpected beat: log_value=%h invalid=%b", log_value, invalid);
                    errs++;
                end
                else
                begin
                    want = expected_logs.pop_front();
                    if (invalid)
                        invalid_seen <= invalid_seen + 1;
                    if (log_value !== want.log_value)
                    begin
                        $error("log_value: expected %h, got %h", want.log_value, log_value);
                        errs++;
                    end
                    if (invalid !== want.invalid)
                    begin
                        $error("invalid: expected %b, got %b", want.invalid, invalid);
                        errs++;
                    end
                end
                error_count <= error_count + errs;
            end
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                stall_len <= stall_len - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_len <= pick_gap();
            end
        end
    end

    // Watchdog on accepted beats; drain and report at the end.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (!(stim_done && expected_logs.size() == 0))
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: %0d beats still expected", expected_logs.size());
                $display("natural_log_series: mismatch");
                $finish;
            end
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d arguments in, %0d log results out, %0d zero arguments.",
                 beats_in, beats_out, invalid_seen);
        if (error_count == 0 && expected_logs.size() == 0)
            $display("natural_log_series: match");
        else
            $display("natural_log_series: mismatch");
        $finish;
    end

endmodule
